/* rtl/vector_softmax_assert.svh */
// assertion macros for the softmax block
`ifndef VECTOR_SOFTMAX_ASSERT_SVH
`define VECTOR_SOFTMAX_ASSERT_SVH

// same-cycle implication
`define VSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vsm_pkg.sv */
// shared types, constants and lookup tables of the softmax block
package vsm_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int NEG_W       = 18;
  localparam int BASE_W      = 19;
  localparam logic [19:0] LN2_Q16 = 20'd45426;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last_in;
  } vsm_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        last_out;
    logic        overflow;
  } vsm_out_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last;
    logic               keep;
  } vsm_cmd_t;

  typedef struct packed {
    logic     valid;
    vsm_cmd_t cmd;
  } vsm_q_t;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_LNA  = 6'b000100,
    ST_LNB  = 6'b001000,
    ST_LNC  = 6'b010000,
    ST_EMIT = 6'b100000
  } vsm_state_t;

  localparam logic [15:0] EXP_HI [16] = '{
    16'd65535, 16'd61565, 16'd57835, 16'd54331, 16'd51039, 16'd47947, 16'd45042, 16'd42313,
    16'd39750, 16'd37341, 16'd35079, 16'd32954, 16'd30957, 16'd29081, 16'd27319, 16'd25664
  };

  localparam logic [15:0] EXP_LO [16] = '{
    16'd65535, 16'd65280, 16'd65026, 16'd64772, 16'd64520, 16'd64268, 16'd64018, 16'd63768,
    16'd63520, 16'd63272, 16'd63025, 16'd62780, 16'd62535, 16'd62291, 16'd62048, 16'd61806
  };

  // entry zero of the fine tables is 1.0, which does not fit 16 bits
  function automatic logic [16:0] exp_hi(input logic [3:0] idx);
    exp_hi = (idx == 4'd0) ? 17'd65536 : {1'b0, EXP_HI[idx]};
  endfunction

  function automatic logic [16:0] exp_lo(input logic [3:0] idx);
    exp_lo = (idx == 4'd0) ? 17'd65536 : {1'b0, EXP_LO[idx]};
  endfunction

  function automatic logic [16:0] exp_int(input logic [3:0] idx);
    case (idx)
      4'd0:    exp_int = 17'd65536;
      4'd1:    exp_int = 17'd24109;
      4'd2:    exp_int = 17'd8869;
      4'd3:    exp_int = 17'd3263;
      4'd4:    exp_int = 17'd1200;
      4'd5:    exp_int = 17'd442;
      4'd6:    exp_int = 17'd162;
      4'd7:    exp_int = 17'd60;
      4'd8:    exp_int = 17'd22;
      4'd9:    exp_int = 17'd8;
      4'd10:   exp_int = 17'd3;
      4'd11:   exp_int = 17'd1;
      default: exp_int = 17'd0;
    endcase
  endfunction

  function automatic logic [15:0] ln_tab(input logic [4:0] idx);
    case (idx)
      5'd0:    ln_tab = 16'd0;
      5'd1:    ln_tab = 16'd3973;
      5'd2:    ln_tab = 16'd7719;
      5'd3:    ln_tab = 16'd11262;
      5'd4:    ln_tab = 16'd14624;
      5'd5:    ln_tab = 16'd17821;
      5'd6:    ln_tab = 16'd20870;
      5'd7:    ln_tab = 16'd23783;
      5'd8:    ln_tab = 16'd26573;
      5'd9:    ln_tab = 16'd29248;
      5'd10:   ln_tab = 16'd31818;
      5'd11:   ln_tab = 16'd34292;
      5'd12:   ln_tab = 16'd36675;
      5'd13:   ln_tab = 16'd38975;
      5'd14:   ln_tab = 16'd41196;
      5'd15:   ln_tab = 16'd43345;
      5'd16:   ln_tab = 16'd45426;
      default: ln_tab = 16'd0;
    endcase
  endfunction

endpackage

/* rtl/vsm_ram.sv */
// generic single-port-write ram with registered read
module vsm_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                       wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                       rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/vsm_front.sv */
// front end: takes beats, marks kept or dropped elements, queues them
module vsm_front #(
  parameter int MaxLen = vsm_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  vsm_pkg::vsm_in_t in_data,
  output vsm_pkg::vsm_q_t  q_head,
  input  logic             q_pop
);
  import vsm_pkg::*;

  localparam int CntW = $clog2(MaxLen + 1);

  vsm_cmd_t           entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;
  logic [QPTR_W:0]    fill_next;
  logic [CntW-1:0]    fcount;
  logic               accept;
  logic               keep;

  assign in_stall = (fill == (QPTR_W + 1)'(QDEPTH));
  assign accept   = in_valid && !in_stall;
  assign keep     = (fcount < CntW'(MaxLen));

  assign q_head.valid = (fill != '0);
  assign q_head.cmd   = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (accept && !q_pop) begin
      fill_next = fill + 1'b1;
    end else if (!accept && q_pop) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= '{score: in_data.score, last: in_data.last_in, keep: keep};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      fcount <= '0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
        if (in_data.last_in) begin
          fcount <= '0;
        end else if (keep) begin
          fcount <= fcount + 1'b1;
        end
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end
endmodule

/* rtl/vsm_exp.sv */
// three-stage exp(-n) unit, unsigned q10.8 argument to q1.16 result
module vsm_exp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [vsm_pkg::NEG_W-1:0] n,
  output logic                      out_valid,
  output logic [16:0]               r
);
  import vsm_pkg::*;

  logic        v0;
  logic        v1;
  logic [16:0] r0;
  logic [16:0] r1;
  logic [3:0]  hi0;
  logic [3:0]  lo0;
  logic [3:0]  lo1;
  logic [33:0] p1;
  logic [33:0] p2;

  assign p1 = 34'(r0) * 34'(exp_hi(hi0)) + 34'd32768;
  assign p2 = 34'(r1) * 34'(exp_lo(lo1)) + 34'd32768;

  always_ff @(posedge clk) begin
    r0  <= (n >= NEG_W'(3072)) ? 17'd0 : exp_int(n[11:8]);
    hi0 <= n[7:4];
    lo0 <= n[3:0];
    r1  <= p1[32:16];
    lo1 <= lo0;
    r   <= p2[32:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end
endmodule

/* rtl/vsm_back.sv */
// back end: stores elements, sums exponentials, takes the log, emits probabilities
module vsm_back #(
  parameter int MaxLen = vsm_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  vsm_pkg::vsm_q_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output vsm_pkg::vsm_out_t out_data
);
  import vsm_pkg::*;

  localparam int CntW  = $clog2(MaxLen + 1);
  localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int SumW  = $clog2(MaxLen) + 17;

  vsm_state_t             state;
  logic [CntW-1:0]        count;
  logic signed [15:0]     run_max;
  logic signed [15:0]     max_next;
  logic                   dropped;
  logic [CntW-1:0]        issue_cnt;
  logic [CntW-1:0]        ret_cnt;
  logic [SumW-1:0]        exp_sum;
  logic signed [BASE_W-1:0] base;
  logic [3:0]             ln_k;
  logic [3:0]             ln_j;
  logic [11:0]            ln_q;
  logic                   ln_small;
  logic [23:0]            ln_prod;
  logic                   inflight;
  logic                   rd_vld;
  logic                   rd_issue;
  logic [15:0]            rdata;
  logic signed [BASE_W-1:0] diff;
  logic [NEG_W-1:0]       exp_n;
  logic                   exp_vld;
  logic [16:0]            exp_r;
  logic [23:0]            s_ext;
  logic [23:0]            s_shift;
  logic [3:0]             k_find;
  logic [15:0]            ln_step;
  logic [19:0]            ln_total;
  logic [19:0]            ln_round;
  logic [11:0]            ln_val;
  logic                   emit_last;

  assign q_pop = q_head.valid && (state == ST_LOAD);
  assign max_next = (q_head.cmd.keep && (q_head.cmd.score > run_max)) ? q_head.cmd.score
                                                                       : run_max;

  always_comb begin
    rd_issue = 1'b0;
    if (state == ST_SUM) begin
      rd_issue = (issue_cnt < count);
    end else if (state == ST_EMIT) begin
      rd_issue = !inflight && !out_valid;
    end
  end

  vsm_ram #(.Width(16), .Depth(MaxLen)) u_store (
    .clk  (clk),
    .we   (q_pop && q_head.cmd.keep),
    .waddr(count[AddrW-1:0]),
    .wdata(q_head.cmd.score),
    .raddr(issue_cnt[AddrW-1:0]),
    .rdata(rdata)
  );

  assign diff  = base - BASE_W'(signed'(rdata));
  assign exp_n = diff[BASE_W-1] ? '0 : diff[NEG_W-1:0];

  vsm_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_vld),
    .n        (exp_n),
    .out_valid(exp_vld),
    .r        (exp_r)
  );

  assign s_ext   = 24'(exp_sum);
  assign s_shift = s_ext >> ln_k;

  always_comb begin
    k_find = 4'd0;
    for (int kk = SumW - 17; kk >= 0; kk--) begin
      if ((s_ext >> kk) < 24'd131072) begin
        k_find = 4'(kk);
      end
    end
  end

  assign ln_step  = ln_tab({1'b0, ln_j} + 5'd1) - ln_tab({1'b0, ln_j});
  assign ln_total = 20'(ln_k) * LN2_Q16 + 20'(ln_tab({1'b0, ln_j}))
                  + 20'((ln_prod + 24'd2048) >> 12);
  assign ln_round = ln_total + 20'd128;
  assign ln_val   = ln_small ? 12'd0 : ln_round[19:8];
  assign emit_last = (issue_cnt + 1'b1 == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      run_max   <= 16'sh8000;
      dropped   <= 1'b0;
      issue_cnt <= '0;
      ret_cnt   <= '0;
      exp_sum   <= '0;
      inflight  <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (q_pop) begin
            run_max <= max_next;
            if (q_head.cmd.keep) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (q_head.cmd.last) begin
              state     <= ST_SUM;
              issue_cnt <= '0;
              ret_cnt   <= '0;
              exp_sum   <= '0;
              base      <= BASE_W'(max_next);
            end
          end
        end
        ST_SUM: begin
          if (rd_issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (exp_vld) begin
            exp_sum <= exp_sum + SumW'(exp_r);
            ret_cnt <= ret_cnt + 1'b1;
            if (ret_cnt + 1'b1 == count) begin
              state <= ST_LNA;
            end
          end
        end
        ST_LNA: begin
          ln_small <= (exp_sum < SumW'(65536));
          ln_k     <= k_find;
          state    <= ST_LNB;
        end
        ST_LNB: begin
          ln_j    <= s_shift[15:12];
          ln_q    <= s_shift[11:0];
          state   <= ST_LNC;
        end
        ST_LNC: begin
          ln_prod <= 24'(ln_step) * 24'(ln_q);
          state   <= ST_EMIT;
          issue_cnt <= '0;
          inflight  <= 1'b0;
        end
        ST_EMIT: begin
          if (base == BASE_W'(run_max)) begin
            base <= BASE_W'(run_max) + BASE_W'(ln_val);
          end
          if (rd_issue) begin
            inflight <= 1'b1;
          end
          if (exp_vld) begin
            inflight  <= 1'b0;
            out_valid <= 1'b1;
            out_data.probability <= exp_r[16] ? 16'hFFFF : exp_r[15:0];
            out_data.last_out    <= emit_last;
            out_data.overflow    <= dropped;
            issue_cnt <= issue_cnt + 1'b1;
            if (emit_last) begin
              state   <= ST_LOAD;
              count   <= '0;
              run_max <= 16'sh8000;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

/* rtl/vector_softmax.sv */
// Softmax over a vector of signed Q8.8 scores, one element per input beat, the
// beat with last_in set closing the vector. Up to MaxLen elements are kept;
// later ones are dropped and every result of that vector carries overflow.
// No result appears until the vector closes; then one Q0.16 probability per
// kept element comes out in arrival order, the final one marked by last_out.
// A four-entry queue sits between the input side and the compute side, so
// input beats keep flowing while a previous vector is still being emitted
// until the queue is full. A vector of N kept elements is loaded, its
// exponentials are summed and their logarithm taken; then each element goes
// singly through the element RAM read and the three-stage exponential unit,
// and the next one is read only after its result beat has been taken.
module vector_softmax #(
  parameter int MaxLen = vsm_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vsm_pkg::vsm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vsm_pkg::vsm_out_t out_data
);
  import vsm_pkg::*;

`include "vector_softmax_assert.svh"

  vsm_q_t q_head;
  logic   q_pop;

  vsm_front #(.MaxLen(MaxLen)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  vsm_back #(.MaxLen(MaxLen)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  `VSM_ASSERT_NOW(a_pop_needs_entry, q_pop, q_head.valid, "queue popped while empty")
  `VSM_ASSERT_NEXT(a_gap_after_last, out_valid && !out_stall && out_data.last_out, !out_valid, "result right after vector end")

endmodule
